// File: rtl/core/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the next cycle
`define CXACC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication checked in the same cycle
`define CXACC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/cxacc_pkg.sv
`timescale 1ns / 1ps

package cxacc_pkg;

   localparam int WORD_BITS_DEFAULT     = 32;
   localparam int FRACTION_BITS_DEFAULT = 16;
   localparam int EXPONENT_BITS_DEFAULT = 8;
   localparam int FUNC_BITS             = 3;
   localparam int DIGIT_BITS            = 16;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_CLEAR     = 3'd0,
      FUNC_ADD       = 3'd1,
      FUNC_SUBTRACT  = 3'd2,
      FUNC_MULTIPLY  = 3'd3,
      FUNC_CONJUGATE = 3'd4,
      FUNC_POWER     = 3'd5,
      FUNC_READ      = 3'd6,
      FUNC_INVALID   = 3'd7
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DRAIN,
      ST_ROUND,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/complex_accumulator_alu.sv
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | func, operand_re, operand_im, exponent
// rsp     | out       | rsp_valid / rsp_ready | result_re, result_im, bad_command, saturated
//
// clear, add, subtract, conjugate, read, invalid: accept, EXEC, then DONE
// multiply: MUL, DRAIN, ROUND for each component; D = ceil(WORD_BITS/16); one shared
// word x 17-bit multiplier walks the D digits of both product terms for each component
// power n > 1: n-1 multiplies in turn; power 0 or 1 goes from EXEC straight to DONE
// reset is synchronous and clears the accumulator and all handshake state
// a new request is taken while a result waits on rsp_ready; its result waits in turn
`timescale 1ns / 1ps

module complex_accumulator_alu #(
   parameter int WORD_BITS     = cxacc_pkg::WORD_BITS_DEFAULT,
   parameter int FRACTION_BITS = cxacc_pkg::FRACTION_BITS_DEFAULT,
   parameter int EXPONENT_BITS = cxacc_pkg::EXPONENT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cxacc_pkg::FUNC_BITS-1:0]     req_func,
   input  logic signed [WORD_BITS-1:0]         req_operand_re,
   input  logic signed [WORD_BITS-1:0]         req_operand_im,
   input  logic [EXPONENT_BITS-1:0]            req_exponent,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [WORD_BITS-1:0]         rsp_result_re,
   output logic signed [WORD_BITS-1:0]         rsp_result_im,
   output logic                                rsp_bad_command,
   output logic                                rsp_saturated
);

   localparam int DIGIT_BITS = cxacc_pkg::DIGIT_BITS;
   localparam int DIGITS     = (WORD_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DIG_W      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int EXT_BITS   = DIGITS * DIGIT_BITS;
   localparam int PROD_BITS  = WORD_BITS + DIGIT_BITS + 1;
   localparam int SUM_BITS   = 2 * WORD_BITS + 2;
   localparam bit ONE_FITS   = (FRACTION_BITS <= WORD_BITS - 2);

   localparam logic signed [WORD_BITS-1:0] MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] MIN_W = ~MAX_W;
   localparam logic signed [WORD_BITS-1:0] ONE_W =
      ONE_FITS ? (WORD_BITS'(1) << FRACTION_BITS) : MAX_W;
   localparam logic signed [SUM_BITS-1:0]  HALF  = SUM_BITS'(1) << (FRACTION_BITS - 1);
   localparam logic [DIG_W-1:0]            DIG_LAST = DIG_W'(DIGITS - 1);
   localparam logic [EXPONENT_BITS-1:0]    EXP_ONE  = EXPONENT_BITS'(1);

   function automatic logic signed [WORD_BITS-1:0] clip1(input logic signed [WORD_BITS:0] v);
      logic ovf;
      ovf = v[WORD_BITS] ^ v[WORD_BITS-1];
      if (ovf) begin
         return v[WORD_BITS] ? MIN_W : MAX_W;
      end
      return v[WORD_BITS-1:0];
   endfunction

   cxacc_pkg::state_type state_ff, state_in;
   cxacc_pkg::func_type  func_ff, func_in;

   logic signed [WORD_BITS-1:0] acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;
   logic signed [WORD_BITS-1:0] opr_ff, opr_in, opi_ff, opi_in;
   logic signed [WORD_BITS-1:0] res_re_ff, res_re_in;
   logic [EXPONENT_BITS-1:0]    cnt_ff, cnt_in;
   logic                        comp_ff, comp_in, term_ff, term_in;
   logic [DIG_W-1:0]            dig_ff, dig_in, pshift_ff, pshift_in;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        psub_ff, psub_in, pv_ff, pv_in;
   logic signed [SUM_BITS-1:0]  psum_ff, psum_in;
   logic                        sat_ff, sat_in, bad_ff, bad_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_BITS-1:0] rsp_re_ff, rsp_re_in, rsp_im_ff, rsp_im_in;
   logic                        rsp_bad_ff, rsp_bad_in, rsp_sat_ff, rsp_sat_in;

   logic                        out_free;
   logic signed [WORD_BITS-1:0] a_sel, b_sel;
   logic signed [EXT_BITS-1:0]  b_ext;
   logic [DIGIT_BITS-1:0]       dig_raw;
   logic signed [DIGIT_BITS:0]  dig_s;
   logic signed [PROD_BITS-1:0] mul_out;
   logic signed [SUM_BITS-1:0]  addend, psum_acc, rnd;
   logic                        rnd_fits;
   logic signed [WORD_BITS-1:0] rnd_word;
   logic                        last_issue, is_sub;
   logic signed [WORD_BITS:0]   sum_re, sum_im, neg_im;
   logic signed [WORD_BITS:0]   opr_x, opi_x;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // shared multiplier datapath
   assign a_sel   = term_ff ? acc_im_ff : acc_re_ff;
   assign b_sel   = (term_ff ^ comp_ff) ? opi_ff : opr_ff;
   assign b_ext   = EXT_BITS'(b_sel);
   assign dig_raw = b_ext[dig_ff*DIGIT_BITS +: DIGIT_BITS];
   assign dig_s   = {(dig_ff == DIG_LAST) ? dig_raw[DIGIT_BITS-1] : 1'b0, dig_raw};
   assign mul_out = PROD_BITS'(a_sel) * PROD_BITS'(dig_s);
   assign last_issue = term_ff && (dig_ff == DIG_LAST);

   assign addend   = SUM_BITS'(prod_ff) <<< (pshift_ff * DIGIT_BITS);
   assign psum_acc = psub_ff ? (psum_ff - addend) : (psum_ff + addend);

   // rounding and saturation of one product component
   assign rnd      = psum_ff >>> FRACTION_BITS;
   assign rnd_fits = (&rnd[SUM_BITS-1:WORD_BITS-1]) || !(|rnd[SUM_BITS-1:WORD_BITS-1]);
   assign rnd_word = rnd_fits ? rnd[WORD_BITS-1:0] : (rnd[SUM_BITS-1] ? MIN_W : MAX_W);

   // add, subtract and conjugate
   assign is_sub = (func_ff == cxacc_pkg::FUNC_SUBTRACT);
   assign opr_x  = is_sub ? ~(WORD_BITS+1)'(opr_ff) : (WORD_BITS+1)'(opr_ff);
   assign opi_x  = is_sub ? ~(WORD_BITS+1)'(opi_ff) : (WORD_BITS+1)'(opi_ff);
   assign sum_re = (WORD_BITS+1)'(acc_re_ff) + opr_x + (WORD_BITS+1)'(is_sub);
   assign sum_im = (WORD_BITS+1)'(acc_im_ff) + opi_x + (WORD_BITS+1)'(is_sub);
   assign neg_im = (WORD_BITS+1)'(0) - (WORD_BITS+1)'(acc_im_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cxacc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cxacc_pkg::ST_EXEC;
            end
         end
         cxacc_pkg::ST_EXEC: begin
            state_in = cxacc_pkg::ST_DONE;
            if (func_ff == cxacc_pkg::FUNC_MULTIPLY) begin
               state_in = cxacc_pkg::ST_MUL;
            end else if (func_ff == cxacc_pkg::FUNC_POWER && cnt_ff > EXP_ONE) begin
               state_in = cxacc_pkg::ST_MUL;
            end
         end
         cxacc_pkg::ST_MUL: begin
            if (last_issue) begin
               state_in = cxacc_pkg::ST_DRAIN;
            end
         end
         cxacc_pkg::ST_DRAIN: begin
            state_in = cxacc_pkg::ST_ROUND;
         end
         cxacc_pkg::ST_ROUND: begin
            state_in = cxacc_pkg::ST_MUL;
            if (comp_ff && cnt_ff == EXP_ONE) begin
               state_in = cxacc_pkg::ST_DONE;
            end
         end
         cxacc_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = cxacc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cxacc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == cxacc_pkg::ST_IDLE);
      func_in      = func_ff;
      acc_re_in    = acc_re_ff;
      acc_im_in    = acc_im_ff;
      opr_in       = opr_ff;
      opi_in       = opi_ff;
      res_re_in    = res_re_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      term_in      = term_ff;
      dig_in       = dig_ff;
      pshift_in    = pshift_ff;
      prod_in      = prod_ff;
      psub_in      = psub_ff;
      pv_in        = pv_ff;
      psum_in      = psum_ff;
      sat_in       = sat_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (state_ff)
         cxacc_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in = cxacc_pkg::func_type'(req_func);
               opr_in  = req_operand_re;
               opi_in  = req_operand_im;
               cnt_in  = req_exponent;
               sat_in  = 1'b0;
               bad_in  = 1'b0;
            end
         end
         cxacc_pkg::ST_EXEC: begin
            comp_in = 1'b0;
            term_in = 1'b0;
            dig_in  = '0;
            pv_in   = 1'b0;
            psum_in = HALF;
            case (func_ff)
               cxacc_pkg::FUNC_CLEAR: begin
                  acc_re_in = '0;
                  acc_im_in = '0;
               end
               cxacc_pkg::FUNC_ADD, cxacc_pkg::FUNC_SUBTRACT: begin
                  acc_re_in = clip1(sum_re);
                  acc_im_in = clip1(sum_im);
                  sat_in    = (sum_re[WORD_BITS] ^ sum_re[WORD_BITS-1])
                            || (sum_im[WORD_BITS] ^ sum_im[WORD_BITS-1]);
               end
               cxacc_pkg::FUNC_MULTIPLY: begin
                  cnt_in = EXP_ONE;
               end
               cxacc_pkg::FUNC_CONJUGATE: begin
                  acc_im_in = clip1(neg_im);
                  sat_in    = neg_im[WORD_BITS] ^ neg_im[WORD_BITS-1];
               end
               cxacc_pkg::FUNC_POWER: begin
                  if (cnt_ff == '0) begin
                     acc_re_in = ONE_W;
                     acc_im_in = '0;
                     sat_in    = !ONE_FITS;
                  end else begin
                     opr_in = acc_re_ff;
                     opi_in = acc_im_ff;
                     cnt_in = cnt_ff - EXP_ONE;
                  end
               end
               cxacc_pkg::FUNC_READ: begin
                  sat_in = 1'b0;
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
         end
         cxacc_pkg::ST_MUL: begin
            prod_in   = mul_out;
            pshift_in = dig_ff;
            psub_in   = !comp_ff && term_ff;
            pv_in     = 1'b1;
            if (pv_ff) begin
               psum_in = psum_acc;
            end
            if (dig_ff == DIG_LAST) begin
               term_in = 1'b1;
               dig_in  = '0;
            end else begin
               dig_in  = dig_ff + 1'b1;
            end
         end
         cxacc_pkg::ST_DRAIN: begin
            psum_in = psum_acc;
            pv_in   = 1'b0;
         end
         cxacc_pkg::ST_ROUND: begin
            sat_in  = sat_ff || !rnd_fits;
            term_in = 1'b0;
            dig_in  = '0;
            pv_in   = 1'b0;
            psum_in = HALF;
            if (!comp_ff) begin
               res_re_in = rnd_word;
               comp_in   = 1'b1;
            end else begin
               acc_re_in = res_re_ff;
               acc_im_in = rnd_word;
               comp_in   = 1'b0;
               cnt_in    = cnt_ff - EXP_ONE;
            end
         end
         cxacc_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = acc_re_ff;
               rsp_im_in    = acc_im_ff;
               rsp_bad_in   = bad_ff;
               rsp_sat_in   = sat_ff;
            end
         end
         default: begin
            pv_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cxacc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_re_ff    <= '0;
         acc_im_ff    <= '0;
         pv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_re_ff    <= acc_re_in;
         acc_im_ff    <= acc_im_in;
         pv_ff        <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      opr_ff     <= opr_in;
      opi_ff     <= opi_in;
      res_re_ff  <= res_re_in;
      cnt_ff     <= cnt_in;
      comp_ff    <= comp_in;
      term_ff    <= term_in;
      dig_ff     <= dig_in;
      pshift_ff  <= pshift_in;
      prod_ff    <= prod_in;
      psub_ff    <= psub_in;
      psum_ff    <= psum_in;
      sat_ff     <= sat_in;
      bad_ff     <= bad_in;
      rsp_re_ff  <= rsp_re_in;
      rsp_im_ff  <= rsp_im_in;
      rsp_bad_ff <= rsp_bad_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_re   = rsp_re_ff;
   assign rsp_result_im   = rsp_im_ff;
   assign rsp_bad_command = rsp_bad_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

// File: rtl/core/cxacc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cxacc_checker #(
   parameter int WORD_BITS = cxacc_pkg::WORD_BITS_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [WORD_BITS-1:0]     rsp_result_re,
   input logic signed [WORD_BITS-1:0]     rsp_result_im,
   input logic                            rsp_bad_command,
   input logic                            rsp_saturated
);

   logic rsp_stall;

   assign rsp_stall = rsp_valid && !rsp_ready;

   // the core is busy right after taking a request
   `CXACC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // an invalid command never reports clipping
   `CXACC_ASSERT_NOW(a_bad_not_sat, clock, reset, rsp_valid && rsp_bad_command, !rsp_saturated)

   // a stalled response stays valid and holds its result
   `CXACC_ASSERT_NEXT(a_rsp_hold_re, clock, reset, rsp_stall, rsp_valid && $stable(rsp_result_re))
   `CXACC_ASSERT_NEXT(a_rsp_hold_im, clock, reset, rsp_stall, rsp_valid && $stable(rsp_result_im))

endmodule

bind complex_accumulator_alu cxacc_checker #(
   .WORD_BITS(WORD_BITS)
) u_cxacc_checker (.*);
